>>> hw/rtl/msx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msx_pkg
// Types, codes and sizes shared by the MIPS-subset execute block.
// ----------------------------------------------------------------------------
package msx_pkg;

	// data memory size in words and its address width
	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	// register file
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);

	// request actions
	localparam logic [1:0] ACT_EXEC        = 2'd0;
	localparam logic [1:0] ACT_PRELOAD_REG = 2'd1;
	localparam logic [1:0] ACT_PRELOAD_MEM = 2'd2;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_JR      = 6'd8;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	// function codes under the special opcode
	localparam logic [5:0] FN_SLL = 6'd0;
	localparam logic [5:0] FN_SRL = 6'd2;
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;

	// link register for jal
	localparam logic [4:0] REG_LINK = 5'd31;

	// marker for no previous destination
	localparam logic [5:0] NONE_DEST = 6'd63;

	// kind of the last executed instruction
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ALU,
		KIND_LOAD,
		KIND_OTHER
	} kind_t;

	// request payload
	typedef struct packed {
		logic        [1:0]  action;
		logic        [31:0] instruction;
		logic        [11:0] preload_index;
		logic signed [31:0] preload_value;
	} req_t;

	// response payload
	typedef struct packed {
		logic        [25:0] next_pc;
		logic               reg_written;
		logic        [4:0]  dest_reg;
		logic signed [31:0] dest_value;
		logic               stall_flag;
		logic               forward_flag;
		logic               halted;
	} rsp_t;

	// register file write
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [31:0]       data;
	} reg_wr_t;

	// state updates produced by the execute logic
	typedef struct packed {
		logic              commit;
		logic [25:0]       pc;
		logic [5:0]        prior_dest;
		kind_t             kind;
		reg_wr_t           reg_wr;
		logic              mem_we;
		logic              is_load;
		logic [MEM_AW-1:0] mem_addr;
		logic [31:0]       mem_data;
	} upd_t;

endpackage
`default_nettype wire

>>> hw/rtl/msx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msx_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module msx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/msx_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msx_regfile
// Two-read register file with reset-to-zero valid bits and a write bypass.
// ----------------------------------------------------------------------------
module msx_regfile (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [msx_pkg::REG_AW-1:0] rs_addr,
	input  wire logic [msx_pkg::REG_AW-1:0] rt_addr,
	input  wire msx_pkg::reg_wr_t           wr,
	output      logic [31:0]               rs_data,
	output      logic [31:0]               rt_data
);

	logic [msx_pkg::REG_COUNT-1:0] valid_q;
	logic [msx_pkg::REG_AW-1:0]    rs_addr_q;
	logic [msx_pkg::REG_AW-1:0]    rt_addr_q;
	logic                          rs_valid_q;
	logic                          rt_valid_q;
	msx_pkg::reg_wr_t              byp_q;
	logic [31:0]                   rs_ram;
	logic [31:0]                   rt_ram;

	// one copy per read port, written together
	msx_ram #(.WIDTH(32), .DEPTH(msx_pkg::REG_COUNT)) u_rs_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rs_addr),
		.rdata (rs_ram)
	);

	msx_ram #(.WIDTH(32), .DEPTH(msx_pkg::REG_COUNT)) u_rt_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rt_addr),
		.rdata (rt_ram)
	);

	// valid bits; an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// capture read addresses, valid bits and the write landing on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q      <= '0;
			rs_valid_q <= 1'b0;
			rt_valid_q <= 1'b0;
			rs_addr_q  <= '0;
			rt_addr_q  <= '0;
		end else if (rd_en) begin
			byp_q      <= wr;
			rs_valid_q <= valid_q[rs_addr];
			rt_valid_q <= valid_q[rt_addr];
			rs_addr_q  <= rs_addr;
			rt_addr_q  <= rt_addr;
		end
	end

	// resolve read data
	always_comb begin
		if (byp_q.en && byp_q.addr == rs_addr_q) begin
			rs_data = byp_q.data;
		end else if (rs_valid_q) begin
			rs_data = rs_ram;
		end else begin
			rs_data = '0;
		end
		if (byp_q.en && byp_q.addr == rt_addr_q) begin
			rt_data = byp_q.data;
		end else if (rt_valid_q) begin
			rt_data = rt_ram;
		end else begin
			rt_data = '0;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/msx_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msx_exec
// Decode, execute, hazard flags and state updates for one request.
// ----------------------------------------------------------------------------
module msx_exec (
	input  wire msx_pkg::req_t  req,
	input  wire logic [31:0]    a,
	input  wire logic [31:0]    b,
	input  wire logic [25:0]    pc,
	input  wire logic [5:0]     prior_dest,
	input  wire msx_pkg::kind_t last_kind,
	input  wire logic [31:0]    mem_rdata,
	output      msx_pkg::rsp_t  rsp,
	output      msx_pkg::upd_t  upd
);

	logic [5:0]  opc;
	logic [4:0]  rs;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [15:0] off;
	logic [25:0] tgt;
	logic [25:0] pc_inc;
	logic [31:0] addr_sum;
	logic [31:0] pidx_ext;
	logic [31:0] srl_bias;
	logic [31:0] srl_sum;
	logic        known;
	logic        use_rs;
	logic        use_rt;
	logic        hit;
	logic [25:0] npc;
	logic        wr;
	logic [4:0]  wreg;
	logic [31:0] wval;

	// instruction fields
	assign opc      = req.instruction[31:26];
	assign rs       = req.instruction[25:21];
	assign rt       = req.instruction[20:16];
	assign rd       = req.instruction[15:11];
	assign sh       = req.instruction[10:6];
	assign fn       = req.instruction[5:0];
	assign off      = req.instruction[15:0];
	assign tgt      = req.instruction[25:0];
	assign pc_inc   = pc + 26'd1;
	assign addr_sum = a + 32'(off[15:2]);
	assign pidx_ext = 32'(req.preload_index);

	// arithmetic right shift rounding toward zero
	assign srl_bias = b[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
	assign srl_sum  = b + srl_bias;

	// decode and execute
	always_comb begin
		known  = 1'b1;
		use_rs = 1'b0;
		use_rt = 1'b0;
		npc    = pc_inc;
		wr     = 1'b0;
		wreg   = '0;
		wval   = '0;
		upd    = '0;
		upd.kind       = msx_pkg::KIND_OTHER;
		upd.prior_dest = msx_pkg::NONE_DEST;
		upd.mem_addr   = addr_sum[msx_pkg::MEM_AW-1:0];
		upd.mem_data   = b;
		unique case (opc)
			msx_pkg::OP_SPECIAL: begin
				use_rs = 1'b1;
				use_rt = 1'b1;
				upd.prior_dest = {1'b0, rd};
				upd.kind = msx_pkg::KIND_ALU;
				wr   = 1'b1;
				wreg = rd;
				unique case (fn)
					msx_pkg::FN_ADD: wval = a + b;
					msx_pkg::FN_SUB: wval = a - b;
					msx_pkg::FN_SLL: wval = b << sh;
					msx_pkg::FN_SRL: wval = 32'($signed(srl_sum) >>> sh);
					default:         known = 1'b0;
				endcase
			end
			msx_pkg::OP_LW: begin
				use_rs = 1'b1;
				upd.prior_dest = {1'b0, rt};
				upd.kind = msx_pkg::KIND_LOAD;
				upd.is_load = 1'b1;
				wr   = 1'b1;
				wreg = rt;
				wval = mem_rdata;
			end
			msx_pkg::OP_SW: begin
				use_rs = 1'b1;
				use_rt = 1'b1;
				upd.mem_we = 1'b1;
			end
			msx_pkg::OP_J: npc = tgt;
			msx_pkg::OP_JAL: begin
				wr   = 1'b1;
				wreg = msx_pkg::REG_LINK;
				wval = 32'(pc) + 32'd1;
				npc  = tgt;
			end
			msx_pkg::OP_JR: begin
				use_rs = 1'b1;
				npc    = a[25:0];
			end
			msx_pkg::OP_BEQ: begin
				use_rs = 1'b1;
				use_rt = 1'b1;
				if (a == b) npc = 26'(off);
			end
			msx_pkg::OP_BNE: begin
				use_rs = 1'b1;
				use_rt = 1'b1;
				if (a != b) npc = 26'(off);
			end
			msx_pkg::OP_BLEZ: begin
				use_rs = 1'b1;
				if ($signed(a) <= 32'sd0) npc = 26'(off);
			end
			msx_pkg::OP_BGTZ: begin
				use_rs = 1'b1;
				if ($signed(a) > 32'sd0) npc = 26'(off);
			end
			default: known = 1'b0;
		endcase

		hit = (prior_dest < 6'd32) &&
			((use_rs && prior_dest[4:0] == rs) || (use_rt && prior_dest[4:0] == rt));

		rsp = '0;
		rsp.next_pc = pc;
		if (req.action == msx_pkg::ACT_EXEC) begin
			if (known) begin
				rsp.next_pc      = npc;
				rsp.reg_written  = wr;
				rsp.dest_reg     = wreg;
				rsp.dest_value   = wval;
				rsp.stall_flag   = hit && last_kind == msx_pkg::KIND_LOAD;
				rsp.forward_flag = hit && last_kind == msx_pkg::KIND_ALU;
				upd.commit       = 1'b1;
				upd.pc           = npc;
				upd.reg_wr.en    = wr;
				upd.reg_wr.addr  = wreg;
				upd.reg_wr.data  = wval;
			end else begin
				rsp.halted  = 1'b1;
				upd.mem_we  = 1'b0;
				upd.is_load = 1'b0;
			end
		end else begin
			// preloads touch neither hazard state nor pc
			upd.mem_we  = 1'b0;
			upd.is_load = 1'b0;
			if (req.action == msx_pkg::ACT_PRELOAD_REG && req.preload_index < 12'd32) begin
				upd.reg_wr.en   = 1'b1;
				upd.reg_wr.addr = req.preload_index[4:0];
				upd.reg_wr.data = req.preload_value;
			end else if (req.action == msx_pkg::ACT_PRELOAD_MEM) begin
				upd.mem_we   = 1'b1;
				upd.mem_addr = pidx_ext[msx_pkg::MEM_AW-1:0];
				upd.mem_data = req.preload_value;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/mips_subset_execute_with_hazard_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_with_hazard_flags
// Executes MIPS-subset instructions or preloads, reporting pc and hazard flags.
// ----------------------------------------------------------------------------
// A request is read from the register file on acceptance and executed in the
// following cycle, so while responses are taken a new request is accepted
// every cycle, except that an lw holds the execute stage while it waits for the
// registered read of the data memory. The response sits in an output register;
// while it waits, one more request can be accepted into the execute stage,
// where it holds until the response is taken. After reset the data memory is
// swept to zero, one word a cycle, over all MEM_WORDS (4096) words; no request
// is taken during the sweep.
module mips_subset_execute_with_hazard_flags (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire msx_pkg::req_t  req_data,
	output      logic           rsp_valid,
	input  wire logic           rsp_ready,
	output      msx_pkg::rsp_t  rsp_data
);

	logic                       valid_s1;
	msx_pkg::req_t              req_s1;
	logic                       lw_wait_q;
	logic                       clearing_q;
	logic [msx_pkg::MEM_AW-1:0] clr_cnt_q;
	logic [25:0]                pc_q;
	logic [5:0]                 prior_dest_q;
	msx_pkg::kind_t             last_kind_q;
	logic [31:0]                rs_data;
	logic [31:0]                rt_data;
	logic [31:0]                mem_rdata;
	msx_pkg::rsp_t              rsp_next;
	msx_pkg::upd_t              upd;
	msx_pkg::reg_wr_t           reg_wr;
	logic                       accept;
	logic                       out_free;
	logic                       s1_done;
	logic                       mem_re;
	logic                       mem_we;
	logic [msx_pkg::MEM_AW-1:0] mem_waddr;
	logic [31:0]                mem_wdata;

	// handshake and stage control
	assign out_free  = !rsp_valid || rsp_ready;
	assign s1_done   = valid_s1 && (!upd.is_load || lw_wait_q) && out_free;
	assign req_ready = !clearing_q && (!valid_s1 || s1_done);
	assign accept    = req_valid && req_ready;
	assign mem_re    = valid_s1 && upd.is_load && !lw_wait_q;

	// register file write at completion
	always_comb begin
		reg_wr    = upd.reg_wr;
		reg_wr.en = upd.reg_wr.en && s1_done;
	end

	// data memory write: clearing sweep or completing store
	assign mem_we    = clearing_q || (s1_done && upd.mem_we);
	assign mem_waddr = clearing_q ? clr_cnt_q : upd.mem_addr;
	assign mem_wdata = clearing_q ? 32'd0 : upd.mem_data;

	msx_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rs_addr (req_data.instruction[25:21]),
		.rt_addr (req_data.instruction[20:16]),
		.wr      (reg_wr),
		.rs_data (rs_data),
		.rt_data (rt_data)
	);

	msx_ram #(.WIDTH(32), .DEPTH(msx_pkg::MEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (upd.mem_addr),
		.rdata (mem_rdata)
	);

	msx_exec u_exec (
		.req        (req_s1),
		.a          (rs_data),
		.b          (rt_data),
		.pc         (pc_q),
		.prior_dest (prior_dest_q),
		.last_kind  (last_kind_q),
		.mem_rdata  (mem_rdata),
		.rsp        (rsp_next),
		.upd        (upd)
	);

	// memory clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + msx_pkg::MEM_AW'(1);
			if (clr_cnt_q == msx_pkg::MEM_AW'(msx_pkg::MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
		end
	end

	// load wait cycle for the data memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_wait_q <= 1'b0;
		end else if (s1_done) begin
			lw_wait_q <= 1'b0;
		end else if (mem_re) begin
			lw_wait_q <= 1'b1;
		end
	end

	// pc and hazard tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= '0;
			prior_dest_q <= msx_pkg::NONE_DEST;
			last_kind_q  <= msx_pkg::KIND_NONE;
		end else if (s1_done && upd.commit) begin
			pc_q         <= upd.pc;
			prior_dest_q <= upd.prior_dest;
			last_kind_q  <= upd.kind;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (s1_done) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			rsp_data <= rsp_next;
		end
	end

	// a load completes only after its memory read cycle
	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done && upd.is_load |-> lw_wait_q)
		else $error("load completed without memory read cycle");

	// no request is in flight during the clearing sweep
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !rsp_valid)
		else $error("request in flight during memory clear");

	// a halted response reports the unchanged pc
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.halted |-> rsp_data.next_pc == pc_q)
		else $error("halted response pc differs from held pc");

endmodule
`default_nettype wire
